// File: hdl/lpfc_pkg.sv
// ----------------------------------------------------------------------------
// lpfc_pkg
// Shared types and constants of the LRU page-frame cache: default sizes,
// fixed port widths, the command bundle to the datapath and the controller status.
// ----------------------------------------------------------------------------
package lpfc_pkg;

    // Default sizes handed down from the top level
    localparam int FRAMES_DEF    = 16;
    localparam int PAGE_BITS_DEF = 20;

    // Fixed widths of the port fields
    localparam int PAGE_NUM_W = 20;
    localparam int FRAME_W    = 4;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;    // capture the request fields
        logic lookup;  // capture tag match and victim choice
        logic commit;  // update frame state and load the result register
    } lpfc_cmd_t;

    // Status formed in the controller from the result valid flag and m_ready
    typedef struct packed {
        logic out_free;  // result register can take a new transaction
    } lpfc_status_t;

endpackage

// File: hdl/lpfc_ctrl.sv
// ----------------------------------------------------------------------------
// lpfc_ctrl
// Request sequencer: accepts a transaction, walks it through lookup and
// commit, and owns the result valid flag.
// ----------------------------------------------------------------------------
module lpfc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output lpfc_pkg::lpfc_cmd_t  cmd
);
    import lpfc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_LOOKUP = 3'b010,
        ST_COMMIT = 3'b100
    } state_t;

    state_t       state_reg;
    state_t       state_next;
    logic         m_valid_reg;
    logic         m_valid_next;
    lpfc_status_t status;
    logic         accept;

    // Result register is free when empty or being drained this cycle
    assign status.out_free = !m_valid_reg || m_ready;

    // Take a new request when idle or as the current one retires
    assign s_ready = (state_reg == ST_IDLE) ||
                     ((state_reg == ST_COMMIT) && status.out_free);
    assign accept  = s_valid && s_ready;

    assign cmd.load   = accept;
    assign cmd.lookup = (state_reg == ST_LOOKUP);
    assign cmd.commit = (state_reg == ST_COMMIT) && status.out_free;

    // Advance the request sequence
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (status.out_free) begin
                    state_next = accept ? ST_LOOKUP : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Set valid on commit, drop it once the result is taken
    always_comb begin
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// File: hdl/lpfc_dp.sv
// ----------------------------------------------------------------------------
// lpfc_dp
// Frame store with parallel tag match, LRU rank vector, victim choice and
// the result register.
// ----------------------------------------------------------------------------
module lpfc_dp #(
    parameter int FRAMES    = lpfc_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lpfc_pkg::PAGE_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  lpfc_pkg::lpfc_cmd_t              cmd,
    input  logic [lpfc_pkg::PAGE_NUM_W-1:0]  s_page_num,
    input  logic                             s_will_write,
    output logic [lpfc_pkg::FRAME_W-1:0]     m_frame,
    output logic                             m_hit,
    output logic                             m_evict_valid,
    output logic [lpfc_pkg::PAGE_NUM_W-1:0]  m_evicted_page,
    output logic                             m_writeback
);
    import lpfc_pkg::*;

    localparam int FW = $clog2(FRAMES);
    localparam int PW = PAGE_BITS;
    localparam int CW = (PW > PAGE_NUM_W) ? PW : PAGE_NUM_W;
    localparam int XW = (FW > FRAME_W) ? FW : FRAME_W;
    localparam logic [FW-1:0] OLDEST = FW'(FRAMES - 1);

    // Request registers
    logic [PW-1:0]     page_in_reg;
    logic              wr_in_reg;
    logic [CW-1:0]     page_in_wide;

    // Frame state
    logic [PW-1:0]     page_reg  [FRAMES];
    logic [FRAMES-1:0] valid_reg;
    logic [FRAMES-1:0] dirty_reg;
    logic [FW-1:0]     rank_reg  [FRAMES];

    // Lookup results
    logic              hit_reg;
    logic [FW-1:0]     sel_reg;
    logic              hit_c;
    logic [FW-1:0]     sel_c;
    logic [FRAMES-1:0] match;
    logic [FRAMES-1:0] victim;

    // Commit values
    logic [FW-1:0]     old_rank;
    logic              ev_valid;
    logic [CW-1:0]     ev_page_wide;
    logic [XW-1:0]     frame_wide;

    // Result registers
    logic [FRAME_W-1:0]    frame_out_reg;
    logic                  hit_out_reg;
    logic                  ev_valid_out_reg;
    logic [PAGE_NUM_W-1:0] ev_page_out_reg;
    logic                  wb_out_reg;

    // Keep the low PAGE_BITS bits of the requested page
    assign page_in_wide = CW'(s_page_num);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            page_in_reg <= page_in_wide[PW-1:0];
            wr_in_reg   <= s_will_write;
        end
    end

    // Compare every valid frame, flag the least recent one
    always_comb begin
        for (int i = 0; i < FRAMES; i++) begin
            match[i]  = valid_reg[i] && (page_reg[i] == page_in_reg);
            victim[i] = (rank_reg[i] == OLDEST);
        end
    end

    // Pick lowest matching frame on a hit, else the oldest frame
    always_comb begin
        hit_c = |match;
        sel_c = '0;
        for (int i = FRAMES - 1; i >= 0; i--) begin
            if (hit_c ? match[i] : victim[i]) begin
                sel_c = FW'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.lookup) begin
            hit_reg <= hit_c;
            sel_reg <= sel_c;
        end
    end

    // Eviction info of the selected frame
    assign old_rank     = rank_reg[sel_reg];
    assign ev_valid     = !hit_reg && valid_reg[sel_reg];
    assign ev_page_wide = ev_valid ? CW'(page_reg[sel_reg]) : '0;
    assign frame_wide   = XW'(sel_reg);

    // Rebind or touch the frame and age the younger ranks
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            dirty_reg <= '0;
            for (int i = 0; i < FRAMES; i++) begin
                rank_reg[i] <= FW'(i);
            end
        end else if (cmd.commit) begin
            for (int i = 0; i < FRAMES; i++) begin
                if (FW'(i) == sel_reg) begin
                    rank_reg[i] <= '0;
                end else if (rank_reg[i] < old_rank) begin
                    rank_reg[i] <= rank_reg[i] + 1'b1;
                end
            end
            if (hit_reg) begin
                dirty_reg[sel_reg] <= dirty_reg[sel_reg] | wr_in_reg;
            end else begin
                valid_reg[sel_reg] <= 1'b1;
                dirty_reg[sel_reg] <= wr_in_reg;
            end
        end
    end

    // Store the new page on a miss
    always_ff @(posedge aclk) begin
        if (cmd.commit && !hit_reg) begin
            page_reg[sel_reg] <= page_in_reg;
        end
    end

    // Load the result register
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            frame_out_reg    <= frame_wide[FRAME_W-1:0];
            hit_out_reg      <= hit_reg;
            ev_valid_out_reg <= ev_valid;
            ev_page_out_reg  <= ev_page_wide[PAGE_NUM_W-1:0];
            wb_out_reg       <= ev_valid && dirty_reg[sel_reg];
        end
    end

    assign m_frame        = frame_out_reg;
    assign m_hit          = hit_out_reg;
    assign m_evict_valid  = ev_valid_out_reg;
    assign m_evicted_page = ev_page_out_reg;
    assign m_writeback    = wb_out_reg;

endmodule

// File: hdl/lru_page_frame_cache_top.sv
// ----------------------------------------------------------------------------
// lru_page_frame_cache_top
// Fully associative page-frame cache with LRU replacement: reports the frame
// for each requested page, and on a miss the evicted page and writeback need.
//
// Channel   Dir  Handshake           Payload
// s_*       in   s_valid / s_ready   s_page_num, s_will_write
// m_*       out  m_valid / m_ready   m_frame, m_hit, m_evict_valid,
//                                    m_evicted_page, m_writeback
//
// Each request passes the lookup state, for the parallel tag match over all frames
// and victim pick, then the commit state, for the rank update and frame commit.
// A new request can be taken as the current one commits, but not during lookup.
// Reset clears valid and dirty marks and sets ranks to the frame index; the
// block takes requests from the first cycle after reset.
// A result waits in the output register; the next request is taken and
// looked up meanwhile, and its commit holds until the register is free.
// ----------------------------------------------------------------------------
module lru_page_frame_cache_top #(
    parameter int FRAMES    = lpfc_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lpfc_pkg::PAGE_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [lpfc_pkg::PAGE_NUM_W-1:0]  s_page_num,
    input  logic                             s_will_write,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [lpfc_pkg::FRAME_W-1:0]     m_frame,
    output logic                             m_hit,
    output logic                             m_evict_valid,
    output logic [lpfc_pkg::PAGE_NUM_W-1:0]  m_evicted_page,
    output logic                             m_writeback
);
    import lpfc_pkg::*;

    lpfc_cmd_t cmd;

    // Sequence requests
    lpfc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Hold frame state and results
    lpfc_dp #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .s_page_num     (s_page_num),
        .s_will_write   (s_will_write),
        .m_frame        (m_frame),
        .m_hit          (m_hit),
        .m_evict_valid  (m_evict_valid),
        .m_evicted_page (m_evicted_page),
        .m_writeback    (m_writeback)
    );

endmodule

// File: hdl/lpfc_checker.sv
// ----------------------------------------------------------------------------
// lpfc_checker
// Port-level checks of the page-frame cache, bound to the top level.
// ----------------------------------------------------------------------------
module lpfc_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [lpfc_pkg::FRAME_W-1:0]     m_frame,
    input logic                             m_hit,
    input logic                             m_evict_valid,
    input logic [lpfc_pkg::PAGE_NUM_W-1:0]  m_evicted_page,
    input logic                             m_writeback
);
    import lpfc_pkg::*;

    // Reset leaves no result pending
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Each request occupies the lookup cycle
    a_lookup_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request taken during lookup");

    // A hit displaces nothing
    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_hit) |-> !m_evict_valid)
        else $error("eviction reported on a hit");

    // No eviction means zero page and no writeback
    a_evict_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_evict_valid) |-> (m_evicted_page == '0) && !m_writeback)
        else $error("eviction fields set without an eviction");

    // A stalled result keeps its valid, frame, hit and evicted page
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_frame) && $stable(m_hit)
            && $stable(m_evicted_page))
        else $error("stalled result changed");

endmodule

bind lru_page_frame_cache_top lpfc_checker u_lpfc_checker (.*);
